>>> design/kpe_pkg.sv
`timescale 1ns / 1ps

package kpe_pkg;

    localparam int ROW_W   = 8;
    localparam int VALUE_W = 32;
    localparam int DIM_W   = 4;
    localparam int IDX_W   = 11;
    localparam int PROD_W  = 64;
    localparam int CFG_W   = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 88;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_B_ROWS = 2'd0,
        CFG_B_COLS = 2'd1
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        op_t                       op;
        logic [ROW_W-1:0]          row;
        logic [ROW_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

>>> design/kpe_front.sv
`timescale 1ns / 1ps

module kpe_front #(
    parameter int MAX_B_ROWS = 8,
    parameter int MAX_B_COLS = 8,
    parameter int MAX_A_DIM  = 256
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kpe_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output kpe_pkg::cmd_t                 q_cmd
);
    import kpe_pkg::*;

    logic in_range;

    always_comb
    begin
        q_cmd.op    = op_t'(s_tuser);
        q_cmd.row   = s_tdata[ROW_W-1:0];
        q_cmd.col   = s_tdata[2*ROW_W-1:ROW_W];
        q_cmd.value = s_tdata[2*ROW_W+VALUE_W-1:2*ROW_W];
        if (q_cmd.op == OP_LOAD)
        begin
            in_range = ({1'b0, q_cmd.row} < 9'(MAX_B_ROWS))
                    && ({1'b0, q_cmd.col} < 9'(MAX_B_COLS));
        end
        else
        begin
            in_range = ({1'b0, q_cmd.row} < 9'(MAX_A_DIM))
                    && ({1'b0, q_cmd.col} < 9'(MAX_A_DIM));
        end
    end

    // drop out-of-range transactions after accepting them
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && in_range;

endmodule

>>> design/kpe_fifo.sv
`timescale 1ns / 1ps

module kpe_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kpe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output kpe_pkg::cmd_t pop_cmd
);
    import kpe_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/kpe_back.sv
`timescale 1ns / 1ps

module kpe_back #(
    parameter int MAX_B_ROWS = 8,
    parameter int MAX_B_COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  kpe_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    input  logic [kpe_pkg::DIM_W-1:0]     rows,
    input  logic [kpe_pkg::DIM_W-1:0]     cols,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kpe_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import kpe_pkg::*;

    localparam int DEPTH = MAX_B_ROWS * MAX_B_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_B_ROWS > 1) ? $clog2(MAX_B_ROWS) : 1;
    localparam int CW    = (MAX_B_COLS > 1) ? $clog2(MAX_B_COLS) : 1;

    logic [VALUE_W-1:0] mem [DEPTH];

    state_t                    state_reg;
    state_t                    state_next;
    logic [RW-1:0]             ib_reg;
    logic [RW-1:0]             ib_next;
    logic [CW-1:0]             jb_reg;
    logic [CW-1:0]             jb_next;
    logic [IDX_W-1:0]          row_base_reg;
    logic [IDX_W-1:0]          col_base_reg;
    logic signed [VALUE_W-1:0] a_reg;

    logic                      s1_valid_reg;
    logic [IDX_W-1:0]          s1_row_reg;
    logic [IDX_W-1:0]          s1_col_reg;
    logic                      s1_last_reg;
    logic signed [VALUE_W-1:0] s1_a_reg;
    logic signed [VALUE_W-1:0] s1_b_reg;

    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_row_reg;
    logic [IDX_W-1:0]          out_col_reg;
    logic signed [PROD_W-1:0]  out_prod_reg;
    logic signed [PROD_W-1:0]  out_prod_next;
    logic                      out_last_reg;

    logic                      advance;
    logic                      mem_we;
    logic                      start;
    logic                      issue;
    logic                      issue_last;
    logic                      row_end;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;

    assign advance    = !out_valid_reg || m_tready;
    assign row_end    = (DIM_W'(jb_reg) == cols - 1'b1);
    assign issue_last = row_end && (DIM_W'(ib_reg) == rows - 1'b1);
    assign wr_addr    = AW'(32'(q_cmd.row) * MAX_B_COLS + 32'(q_cmd.col));
    assign rd_addr    = AW'(32'(ib_reg) * MAX_B_COLS + 32'(jb_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.op == OP_EMIT)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance && issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop  = 1'b0;
        mem_we = 1'b0;
        start  = 1'b0;
        issue  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && (q_cmd.op == OP_LOAD);
                start  = q_valid && (q_cmd.op == OP_EMIT);
            end
            ST_RUN:
            begin
                issue = advance;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ib_next = ib_reg;
        jb_next = jb_reg;
        if (start)
        begin
            ib_next = '0;
            jb_next = '0;
        end
        else if (issue)
        begin
            if (row_end)
            begin
                jb_next = '0;
                ib_next = ib_reg + 1'b1;
            end
            else
            begin
                jb_next = jb_reg + 1'b1;
            end
        end
    end

    assign out_prod_next = s1_a_reg * s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ib_reg        <= '0;
            jb_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ib_reg    <= ib_next;
            jb_reg    <= jb_next;
            if (advance)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= q_cmd.value;
        end
        if (advance)
        begin
            s1_b_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_base_reg <= IDX_W'(q_cmd.row) * IDX_W'(rows);
            col_base_reg <= IDX_W'(q_cmd.col) * IDX_W'(cols);
            a_reg        <= q_cmd.value;
        end
        if (advance)
        begin
            s1_row_reg   <= row_base_reg + IDX_W'(ib_reg);
            s1_col_reg   <= col_base_reg + IDX_W'(jb_reg);
            s1_last_reg  <= issue_last;
            s1_a_reg     <= a_reg;
            out_row_reg  <= s1_row_reg;
            out_col_reg  <= s1_col_reg;
            out_last_reg <= s1_last_reg;
            out_prod_reg <= out_prod_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-PROD_W-2*IDX_W){1'b0}}, out_prod_reg, out_col_reg,
                       out_row_reg};

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command popped while a block is being emitted");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        issue && issue_last |=> state_reg == ST_IDLE)
        else $error("run continues after its last product");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance && s1_valid_reg |=> s1_valid_reg)
        else $error("product lost in stalled pipeline");

    a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (DIM_W'(ib_reg) < rows) && (DIM_W'(jb_reg) < cols))
        else $error("B index beyond configured dimensions");
`endif

endmodule

>>> design/kronecker_product_engine_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                                 Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser       A element or B load
// m_*       out        m_tvalid m_tready m_tdata m_tlast       one product of the block
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  b_rows, b_cols
//
// In the back end a B load is stored when it is popped; an A element is popped, then one
// store read is issued per product, and each product passes the s1 and output registers.
// The store read port and the single multiplier set the one product per cycle while m_tready does not stall.
// Reset clears the queue, the pipeline and sets b_rows = b_cols = 1; the B store is not
// cleared and must be loaded before use. A stalled m_tready holds the back-end pipeline and run,
// while idle pops and B loads go on; the front keeps accepting until the two-entry queue fills.

module kronecker_product_engine_core #(
    parameter int MAX_B_ROWS = 8,
    parameter int MAX_B_COLS = 8,
    parameter int MAX_A_DIM  = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kpe_pkg::S_DATA_W-1:0]  s_tdata,   // row[7:0], col[15:8], value[47:16]
    input  logic                          s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kpe_pkg::M_DATA_W-1:0]  m_tdata,   // result_row[10:0], result_col[21:11],
                                                     // product[85:22], zero[87:86]
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kpe_pkg::CFG_W-1:0]     cfg_index,
    input  logic [kpe_pkg::DIM_W-1:0]     cfg_data
);
    import kpe_pkg::*;

    logic [DIM_W-1:0] b_rows_reg;
    logic [DIM_W-1:0] b_cols_reg;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    cmd_t             push_cmd;
    cmd_t             pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_rows_reg <= DIM_W'(1);
            b_cols_reg <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_B_ROWS: b_rows_reg <= cfg_data;
                CFG_B_COLS: b_cols_reg <= cfg_data;
                default:    b_rows_reg <= b_rows_reg;
            endcase
        end
    end

    // clamp dimensions into 1..max
    always_comb
    begin
        if (b_rows_reg == '0)
            rows = DIM_W'(1);
        else if (b_rows_reg > DIM_W'(MAX_B_ROWS))
            rows = DIM_W'(MAX_B_ROWS);
        else
            rows = b_rows_reg;
        if (b_cols_reg == '0)
            cols = DIM_W'(1);
        else if (b_cols_reg > DIM_W'(MAX_B_COLS))
            cols = DIM_W'(MAX_B_COLS);
        else
            cols = b_cols_reg;
    end

    kpe_front #(
        .MAX_B_ROWS (MAX_B_ROWS),
        .MAX_B_COLS (MAX_B_COLS),
        .MAX_A_DIM  (MAX_A_DIM)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    kpe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    kpe_back #(
        .MAX_B_ROWS (MAX_B_ROWS),
        .MAX_B_COLS (MAX_B_COLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .rows     (rows),
        .cols     (cols),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
